@@ rtl/core/bmh_pkg.sv @@
package bmh_pkg;

	localparam int STATE_WORDS = 8;
	localparam int WORD_W      = 32;
	localparam int IDX_W       = 3;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(STATE_WORDS - 1);

	localparam logic [WORD_W-1:0] K_BASE = 32'h9E37_79B9;
	localparam logic [WORD_W-1:0] K_STEP = 32'h7F4A_7C15;

	localparam logic [4:0] ROT_MAX = 5'd31;

	localparam logic [WORD_W-1:0] INIT_VECTOR [STATE_WORDS] = '{
		32'h243F_6A88, 32'h85A3_08D3, 32'h1319_8A2E, 32'h0370_7344,
		32'hA409_3822, 32'h299F_31D0, 32'h082E_FA98, 32'hEC4E_6C89
	};

	typedef struct packed {
		logic             capture;
		logic             round;
		logic             emit;
		logic             load_iv;
		logic [IDX_W-1:0] idx;
	} cmd_t;

	typedef struct packed {
		logic rounds_done;
	} status_t;

endpackage

@@ rtl/core/bmh_ctrl.sv @@
module bmh_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             has_byte,
	input  logic             is_last,
	output logic             out_valid,
	input  logic             out_ready,
	input  bmh_pkg::status_t status,
	output bmh_pkg::cmd_t    cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_EMIT
	} state_t;

	state_t                    state_q;
	logic                      last_q;
	logic [bmh_pkg::IDX_W-1:0] idx_q;
	logic                      out_valid_q;
	logic                      slot_free;

	assign slot_free   = !out_valid_q || out_ready;
	assign in_ready    = (state_q == ST_IDLE);
	assign out_valid   = out_valid_q;

	assign cmd.capture = in_valid && (state_q == ST_IDLE);
	assign cmd.round   = (state_q == ST_RUN);
	assign cmd.emit    = (state_q == ST_EMIT) && slot_free;
	assign cmd.load_iv = cmd.emit && (idx_q == bmh_pkg::LAST_IDX);
	assign cmd.idx     = idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			last_q      <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						last_q <= is_last;
						if (has_byte) begin
							state_q <= ST_RUN;
						end else if (is_last) begin
							state_q <= ST_EMIT;
							idx_q   <= '0;
						end
					end
				end
				ST_RUN: begin
					if (status.rounds_done) begin
						if (last_q) begin
							state_q <= ST_EMIT;
							idx_q   <= '0;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_EMIT: begin
					if (slot_free) begin
						idx_q <= idx_q + 1'b1;
						if (idx_q == bmh_pkg::LAST_IDX) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

@@ rtl/core/bmh_datapath.sv @@
module bmh_datapath #(
	parameter int MIX_ROUNDS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [7:0]                 data_byte,
	input  bmh_pkg::cmd_t              cmd,
	output bmh_pkg::status_t           status,
	output logic [bmh_pkg::WORD_W-1:0] digest_word,
	output logic [bmh_pkg::IDX_W-1:0]  word_index,
	output logic                       last_word
);

	localparam int NW    = bmh_pkg::STATE_WORDS;
	localparam int WW    = bmh_pkg::WORD_W;
	localparam int RW    = (MIX_ROUNDS > 1) ? $clog2(MIX_ROUNDS) : 1;
	localparam int VRW   = ((RW > 8) ? RW : 8) + 1;
	localparam int ALIGN = (NW - ((MIX_ROUNDS - 1) % NW)) % NW;

	logic [WW-1:0] w_q [NW];
	logic [WW-1:0] w_d [NW];
	logic [WW-1:0] upd [NW];
	logic [7:0]    v_q;
	logic [RW-1:0] r_q;
	logic [WW-1:0] kacc_q;
	logic [4:0]    rot_q;
	logic [WW-1:0] digest_q;
	logic [bmh_pkg::IDX_W-1:0] index_q;
	logic          last_word_q;

	logic          final_round;
	logic [WW-1:0] k;
	logic [WW-1:0] x0;
	logic [WW-1:0] m1;
	logic [WW-1:0] m2;
	logic [WW-1:0] m3;
	logic [VRW-1:0] vr;
	logic [2*WW-1:0] vr_wide;
	logic [WW-1:0] vr_rot;
	logic [WW-1:0] new0;

	assign final_round        = (r_q == RW'(MIX_ROUNDS - 1));
	assign status.rounds_done = cmd.round && final_round;

	assign k       = bmh_pkg::K_BASE ^ kacc_q;
	assign x0      = w_q[0] ^ {24'b0, v_q} ^ k;
	assign m1      = {x0[WW-8:0], x0[WW-1:WW-7]};
	assign m2      = m1 + {w_q[1][10:0], w_q[1][WW-1:11]};
	assign m3      = m2 ^ {w_q[3][WW-18:0], w_q[3][WW-1:WW-17]};
	assign vr      = VRW'(v_q) + VRW'(r_q);
	assign vr_wide = {WW'(vr), WW'(vr)} << rot_q;
	assign vr_rot  = vr_wide[2*WW-1:WW];
	assign new0    = (w_q[0] ^ m3) + vr_rot;

	always_comb begin
		for (int p = 0; p < NW; p++) begin
			upd[p] = w_q[p];
		end
		upd[0] = new0;
		for (int p = 0; p < NW; p++) begin
			w_d[p] = w_q[p];
		end
		if (cmd.round) begin
			for (int p = 0; p < NW; p++) begin
				if (final_round) begin
					w_d[p] = upd[(p + ALIGN) % NW];
				end else begin
					w_d[p] = upd[(p + 1) % NW];
				end
			end
		end else if (cmd.emit) begin
			for (int p = 0; p < NW; p++) begin
				if (cmd.load_iv) begin
					w_d[p] = bmh_pkg::INIT_VECTOR[p];
				end else begin
					w_d[p] = w_q[(p + 1) % NW];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < NW; p++) begin
				w_q[p] <= bmh_pkg::INIT_VECTOR[p];
			end
			r_q    <= '0;
			kacc_q <= '0;
			rot_q  <= 5'd1;
		end else begin
			for (int p = 0; p < NW; p++) begin
				w_q[p] <= w_d[p];
			end
			if (cmd.capture) begin
				r_q    <= '0;
				kacc_q <= '0;
				rot_q  <= 5'd1;
			end else if (cmd.round) begin
				r_q    <= r_q + 1'b1;
				kacc_q <= kacc_q + bmh_pkg::K_STEP;
				rot_q  <= (rot_q == bmh_pkg::ROT_MAX) ? 5'd1 : rot_q + 5'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			v_q <= data_byte;
		end
		if (cmd.emit) begin
			digest_q    <= w_q[0];
			index_q     <= cmd.idx;
			last_word_q <= (cmd.idx == bmh_pkg::LAST_IDX);
		end
	end

	assign digest_word = digest_q;
	assign word_index  = index_q;
	assign last_word   = last_word_q;

endmodule

@@ rtl/core/byte_mixing_hash_256.sv @@
// Byte-serial 256-bit mixing hash. Feed one message or salt byte per input
// beat; mark the final beat with is_last (has_byte may be low there, which
// covers an empty message). A beat with a byte is accepted and then runs
// MIX_ROUNDS rounds through the single round unit, which updates one state
// word per cycle; in_ready stays low meanwhile. A beat without a byte runs none.
// After a last beat the eight state words leave as eight output beats, word 0
// first, at up to one per cycle; the state then returns to the initial vector
// for the next message. A new input beat is taken while the final output beat
// still waits in the output register.
module byte_mixing_hash_256 #(
	parameter int MIX_ROUNDS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        has_byte,
	input  logic        is_last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);

	bmh_pkg::cmd_t    cmd;
	bmh_pkg::status_t status;

	bmh_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.has_byte  (has_byte),
		.is_last   (is_last),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	bmh_datapath #(
		.MIX_ROUNDS (MIX_ROUNDS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.data_byte   (data_byte),
		.cmd         (cmd),
		.status      (status),
		.digest_word (digest_word),
		.word_index  (word_index),
		.last_word   (last_word)
	);

	a_byte_starts_rounds: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && has_byte) |=> cmd.round)
		else $error("accepted byte did not start rounds");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid || out_ready))
		else $error("digest word overwrote a pending beat");

	a_emit_ends_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && cmd.idx == bmh_pkg::LAST_IDX) |=> (in_ready && out_valid && last_word))
		else $error("final digest beat did not return to idle");

endmodule
